[sv/sorted_timer_event_queue_macros.svh]
// assertion macros for the sorted timer event queue
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SORTED_TIMER_EVENT_QUEUE_MACROS_SVH
`define SORTED_TIMER_EVENT_QUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define STQ_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define STQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/stq_pkg.sv]
// shared types and constants for the sorted timer event queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned ID_W        = 4;
  localparam int unsigned PERIOD_W    = 24;
  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned NOW_W       = 32;
  localparam int unsigned DL_W        = 33;
  localparam int unsigned MAX_FIRINGS = 16;
  localparam int unsigned BUDGET_W    = 5;
  localparam int unsigned DIV_W       = 34;
  localparam int unsigned DSR_W       = 10;
  localparam int unsigned SUM_W       = 26;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 24'hFFFFFF;
  localparam logic [PERIOD_W-1:0] JIT_MIN    = 24'd3;
  localparam logic [DSR_W-1:0]    JIT_DIV    = 10'd3;
  localparam logic [DSR_W-1:0]    JIT_SCALE  = 10'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_ADD_JIT = 2'd1,
    OP_DEL     = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[sv/stq_div.sv]
// shared reciprocal divider for the jitter constants; registers operand, then product
// uses stq_pkg for the request and response structs
`timescale 1ns / 1ps
`default_nettype none

module stq_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire stq_pkg::div_req_t req_i,
  output stq_pkg::div_rsp_t      rsp_o
);

  // floor(x / 3) = (x * RECIP_3) >> 33 for any 32-bit x
  localparam logic [31:0] RECIP_3   = 32'hAAAAAAAB;
  localparam int unsigned SHIFT_3   = 33;
  // floor(y / 125) = (y * RECIP_125) >> 35 for any 32-bit y, and x / 1000 = (x >> 3) / 125
  localparam logic [31:0] RECIP_125 = 32'h10624DD3;
  localparam int unsigned SHIFT_125 = 35;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        scale_q, scale_d;
  logic [31:0] opnd_q, opnd_d;
  logic [63:0] prod_q, prod_d;

  always_comb begin
    busy_d  = 1'b0;
    done_d  = 1'b0;
    scale_d = scale_q;
    opnd_d  = opnd_q;
    prod_d  = prod_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      if (req_i.divisor == stq_pkg::JIT_SCALE) begin
        scale_d = 1'b1;
        opnd_d  = {1'b0, req_i.dividend[stq_pkg::DIV_W-1:3]};
      end else begin
        scale_d = 1'b0;
        opnd_d  = req_i.dividend[31:0];
      end
    end else if (busy_q) begin
      done_d = 1'b1;
      prod_d = 64'(opnd_q) * 64'(scale_q ? RECIP_125 : RECIP_3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
    opnd_q  <= opnd_d;
    prod_q  <= prod_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = scale_q ? stq_pkg::DIV_W'(prod_q >> SHIFT_125)
                              : stq_pkg::DIV_W'(prod_q >> SHIFT_3);

endmodule

`default_nettype wire

[sv/sorted_timer_event_queue.sv]
// sorted timer queue: add/delete keep the input stalled while the list is walked (one list
// entry per cycle through the deadline and link memories), a jittered add also through two divider passes.
// a tick checks the head entries in turn, does one insert walk per re-armed entry and a closing
// step; results stream one per firing, the last one flagged. reset is asynchronous: the list
// comes up empty, per-slot memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_event_queue #(
  parameter int EVENT_SLOTS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [stq_pkg::OP_W-1:0]     operation_i,
  input  wire logic [stq_pkg::ID_W-1:0]     event_id_i,
  input  wire logic [stq_pkg::PERIOD_W-1:0] period_seconds_i,
  input  wire logic                         one_shot_i,
  input  wire logic [stq_pkg::SAMPLE_W-1:0] jitter_sample_i,
  input  wire logic [stq_pkg::NOW_W-1:0]    now_seconds_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [stq_pkg::ID_W-1:0]     fired_event_o,
  output      logic                         last_of_run_o
);

  localparam int unsigned IW = $clog2(EVENT_SLOTS);
  localparam int unsigned SW = $clog2(EVENT_SLOTS + 1);
  localparam logic [SW-1:0] NIL = SW'(EVENT_SLOTS);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_DIV_A     = 13'b0000000000010,
    S_MUL       = 13'b0000000000100,
    S_DIV_B     = 13'b0000000001000,
    S_UNL_CHK   = 13'b0000000010000,
    S_UNL_WALK  = 13'b0000000100000,
    S_INS_START = 13'b0000001000000,
    S_INS_WALK  = 13'b0000010000000,
    S_LINK      = 13'b0000100000000,
    S_LINK2     = 13'b0001000000000,
    S_TICK_HEAD = 13'b0010000000000,
    S_TICK_CHK  = 13'b0100000000000,
    S_END       = 13'b1000000000000
  } state_e;

  // control
  state_e                         state_q, state_d;
  logic [SW-1:0]                  cur_q, cur_d;
  logic [SW-1:0]                  prev_q, prev_d;
  logic [SW-1:0]                  head_q, head_d;
  logic [SW-1:0]                  count_q, count_d;
  logic [stq_pkg::NOW_W-1:0]      last_q, last_d;
  logic [stq_pkg::BUDGET_W-1:0]   budget_q, budget_d;
  logic [EVENT_SLOTS-1:0]         active_q, active_d;
  logic                           pend_v_q, pend_v_d;
  logic                           out_v_q, out_v_d;

  // payload
  stq_pkg::op_e                   op_q, op_d;
  logic [SW-1:0]                  s_q, s_d;
  logic                           id_ok_q, id_ok_d;
  logic [stq_pkg::PERIOD_W-1:0]   per_q, per_d;
  logic                           once_q, once_d;
  logic [stq_pkg::SAMPLE_W-1:0]   sample_q, sample_d;
  logic [stq_pkg::NOW_W-1:0]      now_q, now_d;
  logic [stq_pkg::PERIOD_W-1:0]   t_q, t_d;
  logic [stq_pkg::DL_W-1:0]       dl_new_q, dl_new_d;
  logic [SW-1:0]                  pend_q, pend_d;
  logic [stq_pkg::ID_W-1:0]       out_id_q, out_id_d;
  logic                           out_last_q, out_last_d;

  // slot memories
  logic [stq_pkg::DL_W-1:0]       dl_mem [EVENT_SLOTS];
  logic [stq_pkg::PERIOD_W:0]     po_mem [EVENT_SLOTS];
  logic [SW-1:0]                  nx_mem [EVENT_SLOTS];
  logic [stq_pkg::DL_W-1:0]       dl_rd_q;
  logic [stq_pkg::PERIOD_W:0]     po_rd_q;
  logic [SW-1:0]                  nx_rd_q;
  logic                           dl_we, po_we, nx_we;
  logic [IW-1:0]                  nx_wa;
  logic [SW-1:0]                  nx_wd;
  logic [IW-1:0]                  rd_idx;
  logic [IW-1:0]                  s_idx;

  stq_pkg::div_req_t              div_req;
  stq_pkg::div_rsp_t              div_rsp;

  logic [stq_pkg::DL_W-1:0]       dl_new;
  logic [stq_pkg::SUM_W-1:0]      jit_sum;
  logic                           out_free;
  state_e                         after_ins;

  stq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_idx     = s_q[IW-1:0];
  assign dl_new    = stq_pkg::DL_W'(now_q) + stq_pkg::DL_W'(per_q);
  assign jit_sum   = stq_pkg::SUM_W'(t_q) + stq_pkg::SUM_W'(div_rsp.quot[stq_pkg::PERIOD_W:0]);
  assign out_free  = !out_v_q || !out_stall_i;
  assign after_ins = (op_q == stq_pkg::OP_TICK) ? S_TICK_HEAD : S_IDLE;
  assign rd_idx    = (cur_d < NIL) ? cur_d[IW-1:0] : '0;

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    head_d     = head_q;
    count_d    = count_q;
    last_d     = last_q;
    budget_d   = budget_q;
    active_d   = active_q;
    pend_v_d   = pend_v_q;
    out_v_d    = out_v_q && out_stall_i;
    op_d       = op_q;
    s_d        = s_q;
    id_ok_d    = id_ok_q;
    per_d      = per_q;
    once_d     = once_q;
    sample_d   = sample_q;
    now_d      = now_q;
    t_d        = t_q;
    dl_new_d   = dl_new_q;
    pend_d     = pend_q;
    out_id_d   = out_id_q;
    out_last_d = out_last_q;
    dl_we      = 1'b0;
    po_we      = 1'b0;
    nx_we      = 1'b0;
    nx_wa      = prev_q[IW-1:0];
    nx_wd      = nx_rd_q;
    div_req    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = stq_pkg::op_e'(operation_i);
          s_d      = SW'(event_id_i);
          id_ok_d  = (32'(event_id_i) < EVENT_SLOTS);
          per_d    = period_seconds_i;
          once_d   = one_shot_i;
          sample_d = jitter_sample_i;
          now_d    = now_seconds_i;
          if (operation_i == stq_pkg::OP_TICK) begin
            if (now_seconds_i != last_q) begin
              last_d   = now_seconds_i;
              budget_d = (32'(count_q) > stq_pkg::MAX_FIRINGS) ?
                         stq_pkg::BUDGET_W'(stq_pkg::MAX_FIRINGS) :
                         stq_pkg::BUDGET_W'(count_q);
              state_d  = S_TICK_HEAD;
            end
          end else if (operation_i == stq_pkg::OP_ADD_JIT &&
                       period_seconds_i >= stq_pkg::JIT_MIN &&
                       32'(event_id_i) < EVENT_SLOTS) begin
            // 2p / 3
            div_req.start    = 1'b1;
            div_req.dividend = stq_pkg::DIV_W'({period_seconds_i, 1'b0});
            div_req.divisor  = stq_pkg::JIT_DIV;
            state_d          = S_DIV_A;
          end else begin
            state_d = S_UNL_CHK;
          end
        end
      end
      S_DIV_A: begin
        if (div_rsp.done) begin
          t_d     = div_rsp.quot[stq_pkg::PERIOD_W-1:0];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // sample * t / 1000
        div_req.start    = 1'b1;
        div_req.dividend = stq_pkg::DIV_W'(sample_q) * stq_pkg::DIV_W'(t_q);
        div_req.divisor  = stq_pkg::JIT_SCALE;
        state_d          = S_DIV_B;
      end
      S_DIV_B: begin
        if (div_rsp.done) begin
          per_d   = (jit_sum > stq_pkg::SUM_W'(stq_pkg::PERIOD_MAX)) ?
                    stq_pkg::PERIOD_MAX : jit_sum[stq_pkg::PERIOD_W-1:0];
          state_d = S_UNL_CHK;
        end
      end
      S_UNL_CHK: begin
        if (!id_ok_q) begin
          state_d = S_IDLE;
        end else if (active_q[s_idx]) begin
          cur_d   = head_q;
          prev_d  = NIL;
          state_d = S_UNL_WALK;
        end else if (op_q == stq_pkg::OP_DEL) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_INS_START;
        end
      end
      S_UNL_WALK: begin
        if (cur_q == NIL || cur_q == s_q) begin
          if (cur_q == s_q) begin
            if (prev_q == NIL) begin
              head_d = nx_rd_q;
            end else begin
              nx_we = 1'b1;
            end
          end
          active_d[s_idx] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end
          state_d = (op_q == stq_pkg::OP_DEL) ? S_IDLE : S_INS_START;
        end else begin
          prev_d = cur_q;
          cur_d  = nx_rd_q;
        end
      end
      S_INS_START: begin
        dl_we           = 1'b1;
        po_we           = 1'b1;
        dl_new_d        = dl_new;
        active_d[s_idx] = 1'b1;
        cur_d           = head_q;
        prev_d          = NIL;
        state_d         = S_INS_WALK;
      end
      S_INS_WALK: begin
        // stop before the first strictly later deadline
        if (cur_q == NIL || dl_rd_q > dl_new_q) begin
          state_d = S_LINK;
        end else begin
          prev_d = cur_q;
          cur_d  = nx_rd_q;
        end
      end
      S_LINK: begin
        nx_we   = 1'b1;
        nx_wa   = s_idx;
        nx_wd   = cur_q;
        count_d = count_q + 1'b1;
        if (prev_q == NIL) begin
          head_d  = s_q;
          state_d = after_ins;
        end else begin
          state_d = S_LINK2;
        end
      end
      S_LINK2: begin
        nx_we   = 1'b1;
        nx_wd   = s_q;
        state_d = after_ins;
      end
      S_TICK_HEAD: begin
        if (budget_q == '0 || head_q == NIL) begin
          state_d = S_END;
        end else if (out_free) begin
          budget_d = budget_q - 1'b1;
          cur_d    = head_q;
          state_d  = S_TICK_CHK;
        end
      end
      S_TICK_CHK: begin
        if (dl_rd_q > {1'b0, now_q}) begin
          state_d = S_END;
        end else begin
          head_d                   = nx_rd_q;
          active_d[cur_q[IW-1:0]]  = 1'b0;
          count_d                  = count_q - 1'b1;
          // the previous firing is known not to be the last
          if (pend_v_q) begin
            out_v_d    = 1'b1;
            out_id_d   = stq_pkg::ID_W'(pend_q);
            out_last_d = 1'b0;
          end
          pend_v_d = 1'b1;
          pend_d   = cur_q;
          if (!po_rd_q[stq_pkg::PERIOD_W]) begin
            s_d     = cur_q;
            per_d   = po_rd_q[stq_pkg::PERIOD_W-1:0];
            once_d  = 1'b0;
            state_d = S_INS_START;
          end else begin
            state_d = S_TICK_HEAD;
          end
        end
      end
      S_END: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_v_d    = 1'b1;
          out_id_d   = stq_pkg::ID_W'(pend_q);
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cur_q    <= NIL;
      prev_q   <= NIL;
      head_q   <= NIL;
      count_q  <= '0;
      last_q   <= '0;
      budget_q <= '0;
      active_q <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      prev_q   <= prev_d;
      head_q   <= head_d;
      count_q  <= count_d;
      last_q   <= last_d;
      budget_q <= budget_d;
      active_q <= active_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    s_q        <= s_d;
    id_ok_q    <= id_ok_d;
    per_q      <= per_d;
    once_q     <= once_d;
    sample_q   <= sample_d;
    now_q      <= now_d;
    t_q        <= t_d;
    dl_new_q   <= dl_new_d;
    pend_q     <= pend_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

  // read data belongs to the entry at cur_q whenever cur_q is not NIL
  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[s_idx] <= dl_new;
    end
    if (po_we) begin
      po_mem[s_idx] <= {once_q, per_q};
    end
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    dl_rd_q <= dl_mem[rd_idx];
    po_rd_q <= po_mem[rd_idx];
    nx_rd_q <= nx_mem[rd_idx];
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_v_q;
  assign fired_event_o = out_id_q;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

[sv/stq_chk.sv]
// port-level checks for the sorted timer event queue, bound to the top level
// uses stq_pkg and the assertion macros header
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_timer_event_queue_macros.svh"

module stq_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic [stq_pkg::OP_W-1:0]     operation_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [stq_pkg::ID_W-1:0]     fired_event_o,
  input wire logic                         last_of_run_o
);

  // stalled result holds
  `STQ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(fired_event_o) && $stable(last_of_run_o), "stalled result changed")

  // every non-tick request occupies the sequencer
  `STQ_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o && operation_i != stq_pkg::OP_TICK, in_stall_o, "block idle right after a request")

  // a run that is not finished keeps the block busy
  `STQ_ASSERT_IMPL(a_run_busy, out_valid_o && !out_stall_i && !last_of_run_o, in_stall_o, "idle in the middle of a run")

  // results only come from a running tick
  `STQ_ASSERT_IMPL(a_result_src, $rose(out_valid_o), $past(in_stall_o), "result appeared while idle")

endmodule

bind sorted_timer_event_queue stq_chk u_stq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .fired_event_o (fired_event_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire

[tb/tb_sorted_timer_event_queue.sv]
// self-checking testbench for the sorted timer event queue
// depends on stq_pkg and the sorted_timer_event_queue rtl; predicts firings in a scoreboard class
`timescale 1ns / 1ps

module tb_sorted_timer_event_queue;

  localparam int SLOTS = 16;
  localparam int NIL = SLOTS;
  localparam longint CYCLE_LIMIT = 1200000;

  // timer list predictor plus expected firing store
  class firing_board;
    bit              armed[SLOTS];
    logic [32:0]     due_at[SLOTS];
    logic [23:0]     every[SLOTS];
    bit              single[SLOTS];
    int              link[SLOTS];
    int              head;
    int              armed_cnt;
    logic [31:0]     tick_seen;
    logic [4:0]      pending[$];
    int              errors;
    int              fired_total;

    function new();
      head = NIL;
      armed_cnt = 0;
      tick_seen = '0;
      errors = 0;
      fired_total = 0;
      foreach (armed[i]) begin
        armed[i] = 0;
        link[i] = NIL;
      end
    endfunction

    function void unlink(int s);
      int cur, prv;
      if (!armed[s]) return;
      prv = NIL;
      cur = head;
      while (cur != NIL) begin
        if (cur == s) begin
          if (prv == NIL) head = link[cur];
          else link[prv] = link[cur];
          break;
        end
        prv = cur;
        cur = link[cur];
      end
      armed[s] = 0;
      armed_cnt--;
    endfunction

    function void arm(int s, logic [31:0] now);
      int cur, prv;
      logic [32:0] dl;
      unlink(s);
      dl = {1'b0, now} + {9'd0, every[s]};
      due_at[s] = dl;
      armed[s] = 1;
      prv = NIL;
      cur = head;
      while (cur != NIL && due_at[cur] <= dl) begin
        prv = cur;
        cur = link[cur];
      end
      link[s] = cur;
      if (prv == NIL) head = s;
      else link[prv] = s;
      armed_cnt++;
    endfunction

    function void note_request(stq_pkg::op_e op, logic [3:0] id, logic [23:0] per, bit once,
                               logic [9:0] smp, logic [31:0] now);
      int budget, n, s;
      logic [35:0] t, p;
      if (op == stq_pkg::OP_TICK) begin
        if (now == tick_seen) return;
        tick_seen = now;
        budget = armed_cnt > int'(stq_pkg::MAX_FIRINGS) ? int'(stq_pkg::MAX_FIRINGS)
                                                         : armed_cnt;
        n = 0;
        while (budget > 0 && head != NIL) begin
          s = head;
          budget--;
          if (due_at[s] > {1'b0, now}) break;
          unlink(s);
          pending.push_back({s[3:0], 1'b0});
          n++;
          if (!single[s]) arm(s, now);
        end
        if (n > 0) pending[pending.size()-1][0] = 1'b1;
        return;
      end
      if (op == stq_pkg::OP_DEL) begin
        unlink(int'(id));
        return;
      end
      if (op == stq_pkg::OP_ADD_JIT && per >= 3) begin
        t = ({12'd0, per} * 2) / 3;
        p = t + ({26'd0, smp} * t) / 1000;
        per = p > 36'hFFFFFF ? 24'hFFFFFF : p[23:0];
      end
      every[id] = per;
      single[id] = once;
      arm(int'(id), now);
    endfunction

    function void check_firing(logic [3:0] ev, logic last);
      logic [4:0] want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected firing: event %0d last %0b", ev, last);
        return;
      end
      want = pending.pop_front();
      fired_total++;
      if (want != {ev, last}) begin
        errors++;
        if (errors <= 10)
          $display("firing mismatch: expected event %0d last %0b, got event %0d last %0b",
                   want[4:1], want[0], ev, last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [stq_pkg::OP_W-1:0] operation_i = '0;
  logic [stq_pkg::ID_W-1:0] event_id_i = '0;
  logic [stq_pkg::PERIOD_W-1:0] period_seconds_i = '0;
  logic one_shot_i = 1'b0;
  logic [stq_pkg::SAMPLE_W-1:0] jitter_sample_i = '0;
  logic [stq_pkg::NOW_W-1:0] now_seconds_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [stq_pkg::ID_W-1:0] fired_event_o;
  logic last_of_run_o;

  firing_board board = new();
  longint cycles = 0;
  int requests_sent = 0;
  bit src_quiet = 0;      // stretch with no idling
  bit sink_quiet = 0;
  int hold_off = 0;       // long receiver stall in cycles
  logic [31:0] clock_now = 32'd100;

  always #5 clk_i = ~clk_i;

  sorted_timer_event_queue #(.EVENT_SLOTS(SLOTS)) uut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_firing(fired_event_o, last_of_run_o);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !sink_quiet && ($urandom_range(0, 99) < 10);
    end
  end

  // valid stays high after a request so the next one can follow directly
  task automatic send_request(stq_pkg::op_e op, logic [3:0] id, logic [23:0] per, bit once,
                              logic [9:0] smp, logic [31:0] now);
    while (!src_quiet && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    event_id_i <= id;
    period_seconds_i <= per;
    one_shot_i <= once;
    jitter_sample_i <= smp;
    now_seconds_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(op, id, per, once, smp, now);
    requests_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  // mostly small periods so ticks fire often; a few full-range ones
  function automatic logic [23:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 24'd0;
    if (r < 85) return 24'($urandom_range(1, 12));
    if (r < 95) return 24'($urandom_range(13, 5000));
    return 24'($urandom);
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      clock_now = clock_now + $urandom_range(0, 6);
      if ($urandom_range(0, 49) == 0) clock_now = $urandom;
      send_request(stq_pkg::OP_TICK, 4'($urandom), 24'($urandom), 1'($urandom),
                   10'($urandom), clock_now);
    end else if (r < 60) begin
      send_request(stq_pkg::OP_ADD, 4'($urandom), pick_period(), $urandom_range(0, 3) == 0,
                   10'($urandom), clock_now);
    end else if (r < 85) begin
      send_request(stq_pkg::OP_ADD_JIT, 4'($urandom), pick_period(),
                   $urandom_range(0, 3) == 0,
                   ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 999)),
                   clock_now);
    end else begin
      send_request(stq_pkg::OP_DEL, 4'($urandom), 24'($urandom), 1'($urandom),
                   10'($urandom), clock_now);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unchanged tick, equal deadlines in fifo order, zero period refire
    send_request(stq_pkg::OP_TICK, 4'd0, 24'd0, 1'b0, 10'd0, 32'd0);
    send_request(stq_pkg::OP_ADD, 4'd0, 24'd5, 1'b1, 10'd0, 32'd10);
    send_request(stq_pkg::OP_ADD, 4'd15, 24'd5, 1'b0, 10'd0, 32'd10);
    send_request(stq_pkg::OP_ADD, 4'd7, 24'd0, 1'b0, 10'd0, 32'd10);
    send_request(stq_pkg::OP_DEL, 4'd9, 24'd0, 1'b0, 10'd0, 32'd10);
    send_request(stq_pkg::OP_TICK, 4'd0, 24'd0, 1'b0, 10'd0, 32'd15);
    send_request(stq_pkg::OP_TICK, 4'd0, 24'd0, 1'b0, 10'd0, 32'd15);
    send_request(stq_pkg::OP_ADD_JIT, 4'd3, 24'hFFFFFF, 1'b0, 10'd1023, 32'hFFFFFFFF);
    send_request(stq_pkg::OP_ADD_JIT, 4'd4, 24'd2, 1'b1, 10'd999, 32'd20);
    send_request(stq_pkg::OP_ADD_JIT, 4'd5, 24'd3, 1'b0, 10'd0, 32'd20);
    send_request(stq_pkg::OP_ADD, 4'd4, 24'd1, 1'b1, 10'h3FF, 32'd20);
    send_request(stq_pkg::OP_DEL, 4'd15, 24'd0, 1'b0, 10'd0, 32'd20);
    send_request(stq_pkg::OP_TICK, 4'd0, 24'd0, 1'b0, 10'd0, 32'd30);
    send_request(stq_pkg::OP_TICK, 4'd0, 24'd0, 1'b0, 10'd0, 32'd25);  // time goes backwards
    send_request(stq_pkg::OP_TICK, 4'd0, 24'd0, 1'b0, 10'd0, 32'hFFFFFFFF);
    drain();

    // fill all slots, then a long receiver hold-off under a burst of ticks
    for (int i = 0; i < SLOTS; i++)
      send_request(stq_pkg::OP_ADD, i[3:0], 24'd0, i[0], 10'd0, clock_now);
    hold_off = 300;
    for (int i = 0; i < 6; i++) begin
      clock_now = clock_now + 1;
      send_request(stq_pkg::OP_TICK, 4'd0, 24'd0, 1'b0, 10'd0, clock_now);
    end
    drain();

    for (int i = 0; i < 400; i++) begin
      if (i == 150) src_quiet = 1;
      if (i == 220) src_quiet = 0;
      if (i == 250) sink_quiet = 1;
      if (i == 300) sink_quiet = 0;
      if (i == 200) drain();
      random_request();
    end
    drain();

    $display("covered %0d requests and %0d firings, including a stalled receiver burst",
             requests_sent, board.fired_total);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d firings outstanding", board.errors, board.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/stq_pkg.sv
sv/stq_div.sv
sv/sorted_timer_event_queue.sv
sv/stq_chk.sv
tb/tb_sorted_timer_event_queue.sv
